@@ hw/rtl/rfp_pkg.sv @@
package rfp_pkg;

    // Largest datagram the receive path hands over, in bytes.
    localparam int unsigned MAX_DATAGRAM = 65536;
    localparam int unsigned SIZE_W       = 17;
    localparam logic [SIZE_W-1:0] IDX_MAX = '1;

    // Depth of the queue between the parser and the result expander.
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_VIDEO_ID    = 2'd0;
    localparam logic [1:0] CFG_AUDIO_ID    = 2'd1;
    localparam logic [1:0] CFG_PEER_ACTIVE = 2'd2;

    // RTCP header codes.
    localparam logic [7:0] PT_RR       = 8'd201;
    localparam logic [7:0] PT_RTPFB    = 8'd205;
    localparam logic [7:0] PT_PSFB     = 8'd206;
    localparam logic [4:0] FMT_ONE     = 5'd1;
    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam int unsigned RR_BLOCK_BYTES = 24;

    typedef enum logic [1:0] {
        EV_KEYFRAME   = 2'd0,
        EV_RETRANSMIT = 2'd1,
        EV_LOSS       = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic [31:0] video_id;
        logic [31:0] audio_id;
        logic        peer_active;
    } t_cfg;

    // One unit of work for the expander: a keyframe request, a loss report,
    // or a NACK entry whose mask still has to be unrolled.
    typedef struct packed {
        t_event_kind kind;
        logic        sel;
        logic [15:0] seq;
        logic [15:0] mask;
        logic [7:0]  loss;
    } t_cmd;

    typedef struct packed {
        t_event_kind kind;
        logic        sel;
        logic [15:0] seq;
        logic [7:0]  loss;
        logic        run_end;
    } t_result;

    // Index of the lowest set bit; zero for an all-zero mask.
    function automatic logic [3:0] lowest_bit(input logic [15:0] v);
        logic [3:0] pos;
        pos = '0;
        for (int i = 15; i >= 0; i--) begin
            if (v[i]) begin
                pos = 4'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ hw/rtl/rtcp_feedback_parser_top.sv @@
// RTCP feedback parser.
// Input channel: one datagram byte per item on i_octet, with the datagram size on
// i_datagram_bytes and i_final_octet marking the last byte. A byte is taken at a
// clock edge where push is high and full is low; full rises only when the
// internal queue of four pending commands is full.
// Result channel: empty low means the oldest result is on the o_ ports; pop takes
// it. A keyframe request or loss report is one result; a NACK entry gives one
// retransmit request plus one per set mask bit, o_run_end marking the last.
// Path: each command goes through the command queue, the expander's current entry
// and its output register. The parser takes one byte per cycle while full is low;
// the expander hands out one result per cycle while pop is high, so a NACK entry
// with k mask bits set gives k + 1 results while the queue holds later commands.
// When pop stays low, results hold, the queue fills, and full then stops input.
// Configuration: write i_cfg_data to register i_cfg_idx (0 video SSRC, 1 audio
// SSRC, 2 streaming flag) while the block is idle. Reset (synchronous, active
// low) clears the configuration and parse state; queue and outputs come up empty.
module rtcp_feedback_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_octet,
    input  logic [16:0] i_datagram_bytes,
    input  logic        i_final_octet,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_event_kind,
    output logic        o_stream_select,
    output logic [15:0] o_seq_number,
    output logic [7:0]  o_loss_fraction,
    output logic        o_run_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import rfp_pkg::*;

    t_cfg    r_cfg;
    logic    accept;
    logic    cmd_valid;
    t_cmd    cmd;
    logic    q_full;
    logic    q_valid;
    t_cmd    q_data;
    logic    q_pop;
    t_result result;

    // Configuration registers, written directly by the plain write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VIDEO_ID:    r_cfg.video_id    <= i_cfg_data;
                CFG_AUDIO_ID:    r_cfg.audio_id    <= i_cfg_data;
                CFG_PEER_ACTIVE: r_cfg.peer_active <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Every byte causes at most one command, so a free queue slot is enough.
    assign full   = q_full;
    assign accept = push && !q_full;

    rfp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_octet          (i_octet),
        .i_datagram_bytes (i_datagram_bytes),
        .i_final_octet    (i_final_octet),
        .i_cfg            (r_cfg),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd)
    );

    rfp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    rfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_data),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_event_kind    = result.kind;
    assign o_stream_select = result.sel;
    assign o_seq_number    = result.seq;
    assign o_loss_fraction = result.loss;
    assign o_run_end       = result.run_end;

endmodule

@@ hw/rtl/rfp_front.sv @@
module rfp_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [7:0]                            i_octet,
    input  logic [rfp_pkg::SIZE_W-1:0]            i_datagram_bytes,
    input  logic                                  i_final_octet,
    input  rfp_pkg::t_cfg                         i_cfg,
    output logic                                  o_cmd_valid,
    output rfp_pkg::t_cmd                         o_cmd
);
    import rfp_pkg::*;

    typedef enum logic [1:0] {
        NT_NONE  = 2'd0,
        NT_VIDEO = 2'd1,
        NT_AUDIO = 2'd2
    } t_nack_target;

    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(MAX_DATAGRAM);

    logic [SIZE_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]        r_first_octet, n_first_octet;
    logic [7:0]        r_packet_type, n_packet_type;
    logic [7:0]        r_len_hi, n_len_hi;
    logic [18:0]       r_declared_length, n_declared_length;
    logic              r_datagram_ok, n_datagram_ok;
    logic [31:0]       r_media_id_shift, n_media_id_shift;
    t_nack_target      r_nack_target, n_nack_target;
    logic [23:0]       r_fci_word, n_fci_word;
    logic              r_block_id_match, n_block_id_match;
    logic [4:0]        r_rr_within, n_rr_within;
    logic [4:0]        r_rr_blk, n_rr_blk;
    logic [9:0]        r_rr_end, n_rr_end;

    logic [SIZE_W-1:0] idx;
    logic [4:0]        fmt;
    logic [15:0]       len16;
    logic [16:0]       len_p1;
    logic [18:0]       plen;
    logic [SIZE_W-1:0] size_cap;
    logic              hdr_ok;
    logic [31:0]       id_next;

    always_comb begin
        idx      = r_byte_index;
        fmt      = r_first_octet[4:0];
        len16    = {r_len_hi, i_octet};
        len_p1   = {1'b0, len16} + 17'd1;
        plen     = {len_p1, 2'b00};
        size_cap = (i_datagram_bytes > SIZE_CAP) ? SIZE_CAP : i_datagram_bytes;
        hdr_ok   = (r_first_octet[7:6] == RTP_VERSION) && (len16 != 16'd0)
                   && (plen <= {2'b00, size_cap});
        id_next  = {r_media_id_shift[23:0], i_octet};

        n_byte_index      = r_byte_index;
        n_first_octet     = r_first_octet;
        n_packet_type     = r_packet_type;
        n_len_hi          = r_len_hi;
        n_declared_length = r_declared_length;
        n_datagram_ok     = r_datagram_ok;
        n_media_id_shift  = r_media_id_shift;
        n_nack_target     = r_nack_target;
        n_fci_word        = r_fci_word;
        n_block_id_match  = r_block_id_match;
        n_rr_within       = r_rr_within;
        n_rr_blk          = r_rr_blk;
        n_rr_end          = r_rr_end;
        o_cmd_valid       = 1'b0;
        o_cmd             = '0;

        if (i_accept) begin
            if (idx == SIZE_W'(0)) begin
                n_first_octet = i_octet;
            end else if (idx == SIZE_W'(1)) begin
                n_packet_type = i_octet;
            end else if (idx == SIZE_W'(2)) begin
                n_len_hi = i_octet;
            end else if (idx == SIZE_W'(3)) begin
                n_declared_length = plen;
                n_datagram_ok     = hdr_ok;
                if (hdr_ok && r_packet_type == PT_PSFB && fmt == FMT_ONE) begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = EV_KEYFRAME;
                end
            end else if (r_datagram_ok && ({2'b00, idx} < r_declared_length)) begin
                if (r_packet_type == PT_RTPFB && fmt == FMT_ONE
                        && r_declared_length >= 19'd16) begin
                    if (idx >= SIZE_W'(8) && idx <= SIZE_W'(11)) begin
                        n_media_id_shift = id_next;
                        if (idx == SIZE_W'(11)) begin
                            if (!i_cfg.peer_active) begin
                                n_nack_target = NT_NONE;
                            end else if (id_next == i_cfg.video_id) begin
                                n_nack_target = NT_VIDEO;
                            end else if (id_next == i_cfg.audio_id) begin
                                n_nack_target = NT_AUDIO;
                            end else begin
                                n_nack_target = NT_NONE;
                            end
                        end
                    end else if (idx >= SIZE_W'(12) && r_nack_target != NT_NONE) begin
                        n_fci_word = {r_fci_word[15:0], i_octet};
                        // FCI entries start at byte 12, so the last byte of
                        // each one sits at an index of 3 modulo 4.
                        if (idx[1:0] == 2'd3) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = EV_RETRANSMIT;
                            o_cmd.sel   = (r_nack_target == NT_AUDIO);
                            o_cmd.seq   = r_fci_word[23:8];
                            o_cmd.mask  = {r_fci_word[7:0], i_octet};
                        end
                    end
                end else if (r_packet_type == PT_RR && idx >= SIZE_W'(8)) begin
                    if (r_rr_blk < fmt && {9'd0, r_rr_end} <= r_declared_length) begin
                        if (r_rr_within < 5'd4) begin
                            n_media_id_shift = id_next;
                            if (r_rr_within == 5'd3) begin
                                n_block_id_match = (id_next == i_cfg.video_id);
                            end
                        end else if (r_rr_within == 5'd4 && r_block_id_match) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = EV_LOSS;
                            o_cmd.loss  = i_octet;
                        end
                    end
                end
            end

            // Report block position, tracked from byte 8 on whatever the type.
            if (idx >= SIZE_W'(8)) begin
                if (r_rr_within == 5'(RR_BLOCK_BYTES - 1)) begin
                    n_rr_within = '0;
                    if (r_rr_blk != '1) begin
                        n_rr_blk = r_rr_blk + 5'd1;
                        n_rr_end = r_rr_end + 10'(RR_BLOCK_BYTES);
                    end
                end else begin
                    n_rr_within = r_rr_within + 5'd1;
                end
            end

            if (r_byte_index != IDX_MAX) begin
                n_byte_index = r_byte_index + SIZE_W'(1);
            end

            if (i_final_octet) begin
                n_byte_index      = '0;
                n_first_octet     = '0;
                n_packet_type     = '0;
                n_len_hi          = '0;
                n_declared_length = '0;
                n_datagram_ok     = 1'b0;
                n_media_id_shift  = '0;
                n_nack_target     = NT_NONE;
                n_fci_word        = '0;
                n_block_id_match  = 1'b0;
                n_rr_within       = '0;
                n_rr_blk          = '0;
                n_rr_end          = 10'(8 + RR_BLOCK_BYTES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index      <= '0;
            r_first_octet     <= '0;
            r_packet_type     <= '0;
            r_len_hi          <= '0;
            r_declared_length <= '0;
            r_datagram_ok     <= 1'b0;
            r_media_id_shift  <= '0;
            r_nack_target     <= NT_NONE;
            r_fci_word        <= '0;
            r_block_id_match  <= 1'b0;
            r_rr_within       <= '0;
            r_rr_blk          <= '0;
            r_rr_end          <= 10'(8 + RR_BLOCK_BYTES);
        end else begin
            r_byte_index      <= n_byte_index;
            r_first_octet     <= n_first_octet;
            r_packet_type     <= n_packet_type;
            r_len_hi          <= n_len_hi;
            r_declared_length <= n_declared_length;
            r_datagram_ok     <= n_datagram_ok;
            r_media_id_shift  <= n_media_id_shift;
            r_nack_target     <= n_nack_target;
            r_fci_word        <= n_fci_word;
            r_block_id_match  <= n_block_id_match;
            r_rr_within       <= n_rr_within;
            r_rr_blk          <= n_rr_blk;
            r_rr_end          <= n_rr_end;
        end
    end

endmodule

@@ hw/rtl/rfp_cmdq.sv @@
module rfp_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfp_pkg::t_cmd  i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rfp_pkg::t_cmd  o_data
);
    import rfp_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CMDQ_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CMDQ_CW'(1);
            end
        end
    end

endmodule

@@ hw/rtl/rfp_back.sv @@
module rfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  rfp_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output rfp_pkg::t_result o_result
);
    import rfp_pkg::*;

    logic        r_cur_valid;
    logic        r_first;
    t_event_kind r_kind;
    logic        r_sel;
    logic [15:0] r_pid;
    logic [15:0] r_rem;
    logic [7:0]  r_loss;

    logic        r_out_valid;
    t_result     r_out;

    logic        advance;
    logic        emit_now;
    logic        last;
    logic        load;
    logic [15:0] rem_next;
    logic [15:0] seq_out;

    always_comb begin
        advance  = !r_out_valid || i_pop;
        emit_now = r_cur_valid && advance;
        rem_next = r_rem & (r_rem - 16'd1);
        last     = r_first ? (r_rem == '0) : (rem_next == '0);
        seq_out  = r_first ? r_pid : (r_pid + {12'd0, lowest_bit(r_rem)} + 16'd1);
        load     = i_cmd_valid && (!r_cur_valid || (emit_now && last));
    end

    assign o_cmd_pop = load;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_cur_valid <= 1'b1;
            end else if (emit_now && last) begin
                r_cur_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= emit_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_first <= 1'b1;
            r_kind  <= i_cmd.kind;
            r_sel   <= i_cmd.sel;
            r_pid   <= i_cmd.seq;
            r_rem   <= i_cmd.mask;
            r_loss  <= i_cmd.loss;
        end else if (emit_now) begin
            r_first <= 1'b0;
            if (!r_first) begin
                r_rem <= rem_next;
            end
        end
        if (emit_now) begin
            r_out.kind    <= r_kind;
            r_out.sel     <= r_sel;
            r_out.seq     <= seq_out;
            r_out.loss    <= r_loss;
            r_out.run_end <= last;
        end
    end

endmodule

@@ tb/feedback_board_pkg.sv @@
package feedback_board_pkg;

    import rfp_pkg::*;

    // Predicts the results of the parser byte by byte and checks the ones that come out.
    class rtcp_event_board;

        typedef enum logic [1:0] {
            NACK_NONE  = 2'd0,
            NACK_VIDEO = 2'd1,
            NACK_AUDIO = 2'd2
        } t_nack_to;

        logic [31:0] video_id;
        logic [31:0] audio_id;
        logic        streaming;

        logic [16:0] byte_pos;
        logic [7:0]  hdr_first;
        logic [7:0]  hdr_type;
        logic [18:0] pkt_len;
        logic        pkt_ok;
        logic [31:0] ssrc_acc;
        t_nack_to    nack_to;
        logic [31:0] fci_acc;
        logic [4:0]  rr_blocks;
        logic        rr_match;

        t_result     awaited[$];
        int unsigned errors;

        function new();
            video_id  = '0;
            audio_id  = '0;
            streaming = 1'b0;
            errors    = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            byte_pos  = '0;
            hdr_first = '0;
            hdr_type  = '0;
            pkt_len   = '0;
            pkt_ok    = 1'b0;
            ssrc_acc  = '0;
            nack_to   = NACK_NONE;
            fci_acc   = '0;
            rr_blocks = '0;
            rr_match  = 1'b0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_VIDEO_ID:    video_id  = data;
                CFG_AUDIO_ID:    audio_id  = data;
                CFG_PEER_ACTIVE: streaming = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void add_result(t_event_kind kind, logic sel, logic [15:0] seq,
                                 logic [7:0] loss);
            t_result r;
            r.kind    = kind;
            r.sel     = sel;
            r.seq     = seq;
            r.loss    = loss;
            r.run_end = 1'b0;
            awaited.insert(awaited.size(), r);
        endfunction

        // Called for every accepted item, in order.
        function void note_octet(logic [7:0] b, logic [16:0] sz_in, logic fin);
            logic [4:0]  fmt;
            logic [15:0] len16;
            logic [15:0] pid;
            logic [15:0] mask;
            logic        sel;
            int unsigned idx;
            int unsigned plen;
            int unsigned sz;
            int unsigned rel;
            int unsigned blk;
            int unsigned offs;
            int unsigned base;
            int          i;
            fmt  = hdr_first[4:0];
            idx  = byte_pos;
            base = awaited.size();
            if (idx == 0) begin
                hdr_first = b;
            end else if (idx == 1) begin
                hdr_type = b;
            end else if (idx == 2) begin
                pkt_len = 19'(b);
            end else if (idx == 3) begin
                len16 = {pkt_len[7:0], b};
                plen  = (32'(len16) + 1) * 4;
                sz    = (sz_in > MAX_DATAGRAM) ? MAX_DATAGRAM : 32'(sz_in);
                pkt_ok = (hdr_first[7:6] == RTP_VERSION) && (plen >= 8) && (plen <= sz);
                pkt_len   = 19'(plen);
                rr_blocks = fmt;
                if (pkt_ok && hdr_type == PT_PSFB && fmt == FMT_ONE) begin
                    add_result(EV_KEYFRAME, 1'b0, 16'd0, 8'd0);
                end
            end else if (pkt_ok && idx < pkt_len) begin
                if (hdr_type == PT_RTPFB && fmt == FMT_ONE && pkt_len >= 16) begin
                    if (idx >= 8 && idx <= 11) begin
                        ssrc_acc = {ssrc_acc[23:0], b};
                        if (idx == 11) begin
                            if (!streaming) begin
                                nack_to = NACK_NONE;
                            end else if (ssrc_acc == video_id) begin
                                nack_to = NACK_VIDEO;
                            end else if (ssrc_acc == audio_id) begin
                                nack_to = NACK_AUDIO;
                            end else begin
                                nack_to = NACK_NONE;
                            end
                        end
                    end else if (idx >= 12 && nack_to != NACK_NONE) begin
                        fci_acc = {fci_acc[23:0], b};
                        if (((idx - 12) & 3) == 3) begin
                            sel  = (nack_to == NACK_AUDIO);
                            pid  = fci_acc[31:16];
                            mask = fci_acc[15:0];
                            add_result(EV_RETRANSMIT, sel, pid, 8'd0);
                            for (i = 0; i < $bits(mask); i++) begin
                                if (mask[i]) begin
                                    add_result(EV_RETRANSMIT, sel, pid + 16'(i + 1), 8'd0);
                                end
                            end
                        end
                    end
                end else if (hdr_type == PT_RR && idx >= 8) begin
                    rel  = idx - 8;
                    blk  = rel / RR_BLOCK_BYTES;
                    offs = rel % RR_BLOCK_BYTES;
                    if (blk < rr_blocks && 8 + RR_BLOCK_BYTES * (blk + 1) <= pkt_len) begin
                        if (offs < 4) begin
                            ssrc_acc = {ssrc_acc[23:0], b};
                            if (offs == 3) begin
                                rr_match = (ssrc_acc == video_id);
                            end
                        end else if (offs == 4 && rr_match) begin
                            add_result(EV_LOSS, 1'b0, 16'd0, b);
                        end
                    end
                end
            end
            if (awaited.size() > base) begin
                awaited[awaited.size() - 1].run_end = 1'b1;
            end
            if (byte_pos != IDX_MAX) begin
                byte_pos = byte_pos + 1'b1;
            end
            if (fin) begin
                clear_parse();
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic sel, logic [15:0] seq,
                                   logic [7:0] loss, logic last);
            t_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0h seq %0h",
                         $time, kind, seq);
                errors++;
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            compare_field("event_kind", want.kind, kind);
            compare_field("stream_select", want.sel, sel);
            compare_field("seq_number", want.seq, seq);
            compare_field("loss_fraction", want.loss, loss);
            compare_field("run_end", want.run_end, last);
        endfunction

    endclass

endpackage

@@ tb/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rfp_pkg::*;
    import feedback_board_pkg::*;

    // The run is bounded by this many clock cycles. A correct run stays inside
    // it even if every byte brought the longest burst under the heaviest
    // receiver stall.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    // A byte that causes no result can still be in flight when the result
    // queue looks drained.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned SEGMENT_BYTES = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_octet;
    logic [16:0] i_datagram_bytes;
    logic        i_final_octet;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_event_kind;
    logic        o_stream_select;
    logic [15:0] o_seq_number;
    logic [7:0]  o_loss_fraction;
    logic        o_run_end;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    rtcp_event_board board;

    // Probability, in percent, that the sender idles before an item and that
    // the receiver holds pop low in a given cycle.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count = 0;

    // The datagram being built and sent, and the size it claims.
    logic [7:0]  dgram[$];
    logic [16:0] dgram_size;

    rtcp_feedback_parser_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_octet          (i_octet),
        .i_datagram_bytes (i_datagram_bytes),
        .i_final_octet    (i_final_octet),
        .empty            (empty),
        .pop              (pop),
        .o_event_kind     (o_event_kind),
        .o_stream_select  (o_stream_select),
        .o_seq_number     (o_seq_number),
        .o_loss_fraction  (o_loss_fraction),
        .o_run_end        (o_run_end),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver decides at each falling edge whether it takes a result at
    // the next rising edge.
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result taken is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_result(o_event_kind, o_stream_select, o_seq_number,
                               o_loss_fraction, o_run_end);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results still expected", $time, board.pending());
        $display("Regression FAIL");
        $finish;
    end

    // Offers one item and holds it until the block takes it. The task starts
    // and ends at a falling edge, and leaves push high so that the next item
    // of a datagram follows without a gap.
    task automatic send_octet(input logic [7:0] b, input logic [16:0] sz, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push             = 1'b1;
        i_octet          = b;
        i_datagram_bytes = sz;
        i_final_octet    = fin;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        board.note_octet(b, sz, fin);
        @(negedge i_clk);
    endtask

    task automatic send_datagram();
        int unsigned k;
        for (k = 0; k < dgram.size(); k++) begin
            send_octet(dgram[k], dgram_size, k == dgram.size() - 1);
        end
    endtask

    // Stops the sender and waits until every predicted result has been taken,
    // then lets the last bytes without results pass through the pipeline.
    task automatic settle();
        push = 1'b0;
        while (board.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register writes go in back to back; the enable drops after the last one.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        board.set_register(idx, data);
        @(negedge i_clk);
    endtask

    // Settings cover random IDs, both extremes in either order, equal IDs
    // (where video has to win) and streaming switched off.
    task automatic apply_setting(input int unsigned s);
        logic [31:0] vid;
        logic [31:0] aud;
        logic        peer;
        vid  = $urandom;
        aud  = $urandom;
        peer = 1'b1;
        case (s)
            1: begin
                vid = 32'h0000_0000;
                aud = 32'hFFFF_FFFF;
            end
            2: begin
                vid = 32'hFFFF_FFFF;
                aud = 32'h0000_0000;
            end
            3: aud = vid;
            4: peer = 1'b0;
            default: ;
        endcase
        write_register(CFG_VIDEO_ID, vid);
        write_register(CFG_AUDIO_ID, aud);
        write_register(CFG_PEER_ACTIVE, {31'd0, peer});
        i_cfg_we = 1'b0;
    endtask

    function automatic void add_octet(input logic [7:0] b);
        dgram.insert(dgram.size(), b);
    endfunction

    task automatic put_word(input logic [31:0] w);
        add_octet(w[31:24]);
        add_octet(w[23:16]);
        add_octet(w[15:8]);
        add_octet(w[7:0]);
    endtask

    task automatic put_header(input logic [7:0] first, input logic [7:0] pt,
                              input logic [15:0] len16);
        add_octet(first);
        add_octet(pt);
        add_octet(len16[15:8]);
        add_octet(len16[7:0]);
    endtask

    // Media SSRCs hit the configured streams most of the time.
    function automatic logic [31:0] pick_ssrc();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 4) begin
            return board.video_id;
        end else if (r < 7) begin
            return board.audio_id;
        end
        return $urandom;
    endfunction

    // Builds one random datagram. Most are well formed NACK, receiver report
    // and PLI packets with random content; the rest are other packet types
    // and formats, raw noise, and packets broken by a bad version, an early
    // last byte, trailing bytes or a size that does not fit the length field.
    task automatic build_random_datagram();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        int unsigned nblk;
        int unsigned plen;
        int unsigned full_len;
        logic [15:0] len16;
        logic [15:0] pid;
        logic [15:0] mask;
        logic [4:0]  rc;
        logic [7:0]  pt;
        logic [1:0]  ver;
        logic        pad;
        dgram.delete();
        pick = $urandom_range(99);
        pad  = 1'($urandom_range(1));
        plen = 0;
        if (pick < 30) begin
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
            len16 = 16'(2 + n);
            put_header({2'b10, pad, FMT_ONE}, PT_RTPFB, len16);
            put_word($urandom);
            put_word(pick_ssrc());
            for (k = 0; k < n; k++) begin
                pid = ($urandom_range(3) == 0) ? (16'hFFF0 | 16'($urandom_range(15)))
                                               : 16'($urandom);
                case ($urandom_range(3))
                    0: mask = 16'h0000;
                    1: mask = 16'hFFFF;
                    default: mask = 16'($urandom);
                endcase
                put_word({pid, mask});
            end
            plen = (32'(len16) + 1) * 4;
        end else if (pick < 50) begin
            rc   = ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(2));
            nblk = ($urandom_range(3) == 0) ? $urandom_range(2) : ((rc > 2) ? 2 : rc);
            len16 = 16'(1 + 6 * nblk);
            put_header({2'b10, pad, rc}, PT_RR, len16);
            put_word($urandom);
            for (k = 0; k < nblk; k++) begin
                put_word(($urandom_range(2) == 0) ? $urandom : pick_ssrc());
                add_octet(8'($urandom));
                repeat (RR_BLOCK_BYTES - 5) add_octet(8'($urandom));
            end
            plen = (32'(len16) + 1) * 4;
        end else if (pick < 65) begin
            len16 = 16'(2 + $urandom_range(2));
            put_header({2'b10, pad, FMT_ONE}, PT_PSFB, len16);
            plen = (32'(len16) + 1) * 4;
        end else if (pick < 85) begin
            case ($urandom_range(3))
                0: pt = PT_PSFB;
                1: pt = PT_RTPFB;
                2: pt = PT_RR;
                default: pt = 8'($urandom);
            endcase
            len16 = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4));
            put_header({2'b10, pad, 5'($urandom)}, pt, len16);
            repeat ($urandom_range(20)) add_octet(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 12)) add_octet(8'($urandom));
        end
        while (dgram.size() < plen) begin
            add_octet(8'($urandom));
        end
        full_len = dgram.size();
        if (pick < 85) begin
            case ($urandom_range(9))
                0: begin
                    ver = 2'($urandom_range(2));
                    if (ver == RTP_VERSION) begin
                        ver = 2'd3;
                    end
                    dgram[0] = {ver, dgram[0][5:0]};
                end
                1: begin
                    repeat ($urandom_range(1, dgram.size() - 1)) void'(dgram.pop_back());
                end
                2: begin
                    repeat ($urandom_range(1, 6)) add_octet(8'($urandom));
                    full_len = dgram.size();
                end
                default: ;
            endcase
        end
        case ($urandom_range(9))
            0: dgram_size = 17'($urandom_range(1, full_len));
            1: dgram_size = 17'($urandom_range(65536, 131071));
            2: dgram_size = 17'(MAX_DATAGRAM);
            3: dgram_size = 17'($urandom);
            default: dgram_size = 17'(full_len);
        endcase
    endtask

    initial begin
        int unsigned mode;
        int unsigned half;
        int unsigned seg_bytes;
        int unsigned idle_send[4];
        int unsigned idle_recv[4];

        board = new();
        push             = 1'b0;
        i_octet          = '0;
        i_datagram_bytes = '0;
        i_final_octet    = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, with the registers still at their reset values.
        // A PLI header cut short right after the length field still gives its
        // keyframe request.
        dgram.delete();
        put_header({2'b10, 1'b0, FMT_ONE}, PT_PSFB, 16'd1);
        dgram_size = 17'd8;
        send_datagram();
        // A size beyond the largest datagram counts as the largest one, so a
        // declared length of exactly that passes and one word more does not.
        dgram.delete();
        put_header({2'b10, 1'b1, FMT_ONE}, PT_PSFB, 16'h3FFF);
        dgram_size = 17'h1FFFF;
        send_datagram();
        dgram.delete();
        put_header({2'b10, 1'b0, FMT_ONE}, PT_PSFB, 16'h4000);
        dgram_size = 17'h1FFFF;
        send_datagram();

        // A NACK with a full mask on the top packet ID gives the longest
        // burst of results, with the sequence numbers wrapping.
        settle();
        apply_setting(0);
        dgram.delete();
        put_header({2'b10, 1'b0, FMT_ONE}, PT_RTPFB, 16'd3);
        put_word($urandom);
        put_word(board.video_id);
        put_word(32'hFFFF_FFFF);
        dgram_size = 17'd16;
        send_datagram();

        // Random part: four idling modes, each under two register settings.
        // The sender drains the block before every setting and now and then
        // between datagrams.
        idle_send[0] = 0;  idle_recv[0] = 0;
        idle_send[1] = 83; idle_recv[1] = 0;
        idle_send[2] = 0;  idle_recv[2] = 83;
        idle_send[3] = 27; idle_recv[3] = 27;
        for (mode = 0; mode < 4; mode++) begin
            send_idle_pct  = idle_send[mode];
            recv_stall_pct = idle_recv[mode];
            for (half = 0; half < 2; half++) begin
                settle();
                apply_setting(mode * 2 + half);
                seg_bytes = 0;
                while (seg_bytes < SEGMENT_BYTES) begin
                    build_random_datagram();
                    send_datagram();
                    seg_bytes += dgram.size();
                    if ($urandom_range(7) == 0) begin
                        settle();
                    end
                end
            end
        end

        settle();
        // Nothing may be left waiting once every prediction has been taken.
        if (!empty) begin
            $display("%0t: unexpected result: expected none, actual kind %0h seq %0h",
                     $time, o_event_kind, o_seq_number);
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
